// File: hdl/u2u_pkg.sv
`timescale 1ns / 1ps

package u2u_pkg;

   // result status codes
   typedef enum logic [2:0] {
      STATUS_OK         = 3'd0,
      STATUS_STRAY      = 3'd1,
      STATUS_BIG_LEAD   = 3'd2,
      STATUS_BAD_CONT   = 3'd3,
      STATUS_RANGE      = 3'd4,
      STATUS_INCOMPLETE = 3'd5
   } status_type;

   typedef struct packed {
      logic [15:0] code_unit;
      status_type  status;
      logic        last_of_run;
   } unit_type;

   // zero, one or two result beats from one input beat
   typedef struct packed {
      logic [1:0] beats;
      unit_type   first;
      unit_type   second;
   } result_type;

   localparam int unsigned FifoDepth = 4;
   localparam int unsigned PtrWidth  = $clog2(FifoDepth);
   localparam int unsigned CntWidth  = $clog2(FifoDepth + 1);

   localparam logic [20:0] PlaneOneBase = 21'h010000;
   localparam logic [20:0] CodeLimit    = 21'h110000;
   localparam logic [15:0] HighSurr     = 16'hD800;
   localparam logic [15:0] LowSurr      = 16'hDC00;
   localparam logic [15:0] ByteOrderMark = 16'hFEFF;
   localparam logic [7:0]  ContLimit    = 8'hC0;
   localparam logic [7:0]  TwoLimit     = 8'hE0;
   localparam logic [7:0]  ThreeLimit   = 8'hF0;
   localparam logic [7:0]  LeadLimit    = 8'hF8;

   // puts a code unit into stream byte order, first byte in bits 7:0
   function automatic logic [15:0] order_unit(input logic [15:0] unit, input logic big_endian);
      order_unit = big_endian ? {unit[7:0], unit[15:8]} : unit;
   endfunction

   function automatic result_type fail_result(input status_type status);
      result_type r;
      r                    = '0;
      r.beats              = 2'd1;
      r.first.code_unit    = 16'h0000;
      r.first.status       = status;
      r.first.last_of_run  = 1'b1;
      fail_result          = r;
   endfunction

endpackage

// File: hdl/u2u_decode.sv
`timescale 1ns / 1ps

module u2u_decode (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic                mode,
   input  logic [7:0]          in_byte,
   input  logic                last_byte,
   input  logic                big_endian,
   output u2u_pkg::result_type result
);
   import u2u_pkg::*;

   logic [20:0] acc_ff, acc_in;
   logic [1:0]  pend_ff, pend_in;
   logic [20:0] shifted;
   logic [20:0] point;
   logic [20:0] offset;
   logic [19:0] pair_bits;
   result_type  emit_res;

   // code point gathered so far plus this continuation's six bits
   assign shifted   = {acc_ff[14:0], in_byte[5:0]};
   assign point     = (pend_ff == 2'd0) ? {13'd0, in_byte} : shifted;
   assign offset    = point - PlaneOneBase;
   assign pair_bits = offset[19:0];

   always_comb begin
      emit_res = '0;
      if (point < PlaneOneBase) begin
         emit_res.beats             = 2'd1;
         emit_res.first.code_unit   = order_unit(point[15:0], big_endian);
         emit_res.first.status      = STATUS_OK;
         emit_res.first.last_of_run = 1'b1;
      end else if (point < CodeLimit) begin
         emit_res.beats              = 2'd2;
         emit_res.first.code_unit    = order_unit(HighSurr | {6'd0, pair_bits[19:10]},
                                                  big_endian);
         emit_res.first.status       = STATUS_OK;
         emit_res.first.last_of_run  = 1'b0;
         emit_res.second.code_unit   = order_unit(LowSurr | {6'd0, pair_bits[9:0]},
                                                  big_endian);
         emit_res.second.status      = STATUS_OK;
         emit_res.second.last_of_run = 1'b1;
      end else begin
         emit_res = fail_result(STATUS_RANGE);
      end
   end

   always_comb begin
      result  = '0;
      acc_in  = acc_ff;
      pend_in = pend_ff;
      if (mode) begin
         // byte order mark, pending sequence untouched
         result.beats             = 2'd1;
         result.first.code_unit   = order_unit(ByteOrderMark, big_endian);
         result.first.status      = STATUS_OK;
         result.first.last_of_run = 1'b1;
      end else if (pend_ff == 2'd0) begin
         priority if (in_byte[7] == 1'b0) begin
            result  = emit_res;
            acc_in  = '0;
            pend_in = 2'd0;
         end else if (in_byte < ContLimit) begin
            result  = fail_result(STATUS_STRAY);
            acc_in  = '0;
            pend_in = 2'd0;
         end else if (in_byte >= LeadLimit) begin
            result  = fail_result(STATUS_BIG_LEAD);
            acc_in  = '0;
            pend_in = 2'd0;
         end else if (last_byte) begin
            result  = fail_result(STATUS_INCOMPLETE);
            acc_in  = '0;
            pend_in = 2'd0;
         end else if (in_byte < TwoLimit) begin
            acc_in  = {16'd0, in_byte[4:0]};
            pend_in = 2'd1;
         end else if (in_byte < ThreeLimit) begin
            acc_in  = {17'd0, in_byte[3:0]};
            pend_in = 2'd2;
         end else begin
            acc_in  = {18'd0, in_byte[2:0]};
            pend_in = 2'd3;
         end
      end else begin
         priority if (in_byte[7:6] != 2'b10) begin
            result  = fail_result(STATUS_BAD_CONT);
            acc_in  = '0;
            pend_in = 2'd0;
         end else if (pend_ff == 2'd1) begin
            result  = emit_res;
            acc_in  = '0;
            pend_in = 2'd0;
         end else if (last_byte) begin
            result  = fail_result(STATUS_INCOMPLETE);
            acc_in  = '0;
            pend_in = 2'd0;
         end else begin
            acc_in  = shifted;
            pend_in = pend_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         pend_ff <= 2'd0;
      end else if (step) begin
         acc_ff  <= acc_in;
         pend_ff <= pend_in;
      end
   end

endmodule

// File: hdl/u2u_out_fifo.sv
`timescale 1ns / 1ps

module u2u_out_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  u2u_pkg::result_type result,
   output logic                room,
   output logic                out_valid,
   input  logic                out_ready,
   output u2u_pkg::unit_type   out_unit
);
   import u2u_pkg::*;

   unit_type               mem_ff [FifoDepth];
   logic [PtrWidth-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]    count_ff, count_in;
   logic [CntWidth-1:0]    push_n;
   logic                   pop;

   assign push_n    = push ? CntWidth'(result.beats) : '0;
   assign pop       = out_valid & out_ready;
   assign out_valid = (count_ff != '0);
   assign out_unit  = mem_ff[rd_ptr_ff];
   // room for a surrogate pair
   assign room      = (count_ff <= CntWidth'(FifoDepth - 2));

   assign wr_ptr_in = wr_ptr_ff + push_n[PtrWidth-1:0];
   assign rd_ptr_in = rd_ptr_ff + PtrWidth'(pop);
   assign count_in  = count_ff + push_n - CntWidth'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && result.beats != 2'd0) begin
         mem_ff[wr_ptr_ff] <= result.first;
      end
      if (push && result.beats == 2'd2) begin
         mem_ff[wr_ptr_ff + PtrWidth'(1)] <= result.second;
      end
   end

endmodule

// File: hdl/utf8_to_utf16_decoder_top.sv
`timescale 1ns / 1ps

// utf-8 to utf-16 transcoder: takes one utf-8 byte per beat on req_ and returns
// utf-16 code units on rsp_, in little- or big-endian byte order as set by the
// one-bit csr register (write it only while idle). a byte is taken every cycle
// as long as the 4-entry result queue has room for two beats; a finished code
// point up to ffff gives one beat, up to 10ffff a surrogate pair of two, else
// an error beat. a pair needs four input bytes, so with rsp_tready held high
// the queue drains faster than it fills and the input runs at one byte per
// cycle. the first result beat of a byte can appear in the cycle after it is
// accepted, later when older beats still wait in the queue. errors give a
// single beat with a nonzero status, code unit zero and tlast set, and drop any
// pending sequence. tuser on req_ asks for a byte order mark instead of data.
// overlong forms are passed through unchecked.

module utf8_to_utf16_decoder_top (
   input  logic        clock,
   input  logic        reset,
   // input byte stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tuser,   // [0] mode: emit byte order mark
   input  logic        req_tlast,   // last_byte
   // code unit stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [15:0] code_unit, [18:16] status, [23:19] zero
   output logic        rsp_tlast,   // last_of_run
   // byte order register
   input  logic        csr_wr_en,
   input  logic        csr_wr_data  // big_endian_out
);
   import u2u_pkg::*;

   logic       big_endian_ff;
   logic       accept;
   logic       room;
   result_type result;
   unit_type   out_unit;

   // config register; the user must write it only while idle, the block does not enforce it
   always_ff @(posedge clock) begin
      if (reset) begin
         big_endian_ff <= 1'b0;
      end else if (csr_wr_en) begin
         big_endian_ff <= csr_wr_data;
      end
   end

   assign req_tready = room;
   assign accept     = req_tvalid & req_tready;

   // sequence state and per-byte result logic
   u2u_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .step       (accept),
      .mode       (req_tuser),
      .in_byte    (req_tdata),
      .last_byte  (req_tlast),
      .big_endian (big_endian_ff),
      .result     (result)
   );

   // result queue, takes up to two beats per cycle, gives one while rsp_tready is high
   u2u_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .result    (result),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_unit  (out_unit)
   );

   assign rsp_tdata = {5'd0, out_unit.status, out_unit.code_unit};
   assign rsp_tlast = out_unit.last_of_run;

endmodule

// File: hdl/u2u_checker.sv
`timescale 1ns / 1ps

module u2u_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tlast
);

   // queue comes out of reset empty and ready
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && req_tready))
      else $error("queue not empty after reset");

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("result beat changed while stalled");

   // an error beat carries no code unit and ends its run
   a_error_beat: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[18:16] != 3'd0) |->
         (rsp_tdata[15:0] == 16'h0000 && rsp_tlast && rsp_tdata[23:19] == 5'd0))
      else $error("malformed error beat");

   // a beat that does not end its run is a high surrogate with ok status
   a_pair_first: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tlast) |->
         (rsp_tdata[18:16] == 3'd0 &&
          (rsp_tdata[15:10] == 6'b110110 || rsp_tdata[7:2] == 6'b110110)))
      else $error("open run on a beat that is not a high surrogate");

   // input acceptance never happens while idle-ready is unknown
   a_ready_known: assert property (@(posedge clock) disable iff (reset)
      req_tvalid |-> !$isunknown(req_tready))
      else $error("req_tready unknown");

endmodule

bind utf8_to_utf16_decoder_top u2u_checker u_checker (.*);

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import u2u_pkg::*;

   localparam int unsigned SettleCycles = 8;     // pause before a csr write and at the end
   localparam int unsigned StallLimit   = 1000;  // cycles with no beat on either side
   localparam int unsigned RandomPerPhase = 225;
   localparam int unsigned ReportLimit  = 10;

   localparam logic [7:0]  TwoByteLead   = 8'hC0;
   localparam logic [7:0]  ThreeByteLead = 8'hE0;
   localparam logic [7:0]  FourByteLead  = 8'hF0;
   localparam logic [7:0]  BadLeadFloor  = 8'hF8;
   localparam logic [20:0] SuppBase      = 21'h010000;
   localparam logic [20:0] CodeCeiling   = 21'h110000;
   localparam logic [15:0] HighSurrogate = 16'hD800;
   localparam logic [15:0] LowSurrogate  = 16'hDC00;
   localparam logic [15:0] BomUnit       = 16'hFEFF;

   typedef struct packed {
      logic       bom;
      logic [7:0] data;
      logic       last;
   } utf8_beat_type;

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata   = 8'h00;
   logic        req_tuser   = 1'b0;
   logic        req_tlast   = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_wr_en   = 1'b0;
   logic        csr_wr_data = 1'b0;

   utf8_beat_type  byte_queue [$];
   unit_type       units_due [$];
   unit_type       want;
   utf8_beat_type  beat_out;

   // predictor state
   logic [20:0] acc_bits;
   logic [1:0]  conts_left;
   logic        cfg_big_endian;

   int unsigned items_queued;
   int unsigned bytes_sent;
   int unsigned units_checked;
   int unsigned error_count;
   int unsigned config_writes;
   int unsigned idle_cycles;
   int unsigned status_hits [8];
   int unsigned send_wait;
   int unsigned recv_wait;
   logic        sender_steady;
   logic        receiver_steady;

   utf8_to_utf16_decoder_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic [15:0] unit_in_stream_order(input logic [15:0] v);
      return cfg_big_endian ? {v[7:0], v[15:8]} : v;
   endfunction

   function automatic void expect_unit(input logic [15:0] cu, input status_type st,
                                       input logic lst);
      unit_type u;
      u.code_unit   = cu;
      u.status      = st;
      u.last_of_run = lst;
      units_due.push_back(u);
   endfunction

   function automatic void expect_error(input status_type st);
      acc_bits   = '0;
      conts_left = '0;
      expect_unit(16'h0000, st, 1'b1);
   endfunction

   // one unit below plane one, a surrogate pair up to 10ffff, else out of range
   function automatic void finish_code_point(input logic [20:0] cp);
      logic [20:0] offset;
      acc_bits   = '0;
      conts_left = '0;
      if (cp < SuppBase) begin
         expect_unit(unit_in_stream_order(cp[15:0]), STATUS_OK, 1'b1);
      end else if (cp < CodeCeiling) begin
         offset = cp - SuppBase;
         expect_unit(unit_in_stream_order(HighSurrogate | {6'd0, offset[19:10]}),
                     STATUS_OK, 1'b0);
         expect_unit(unit_in_stream_order(LowSurrogate | {6'd0, offset[9:0]}),
                     STATUS_OK, 1'b1);
      end else begin
         expect_error(STATUS_RANGE);
      end
   endfunction

   function automatic void decode_utf8_beat(input logic bom, input logic [7:0] d,
                                            input logic last);
      if (bom) begin
         // pending sequence is left alone
         expect_unit(unit_in_stream_order(BomUnit), STATUS_OK, 1'b1);
      end else if (conts_left == 2'd0) begin
         if (d[7] == 1'b0) begin
            finish_code_point({13'd0, d});
         end else if (d < TwoByteLead) begin
            expect_error(STATUS_STRAY);
         end else if (d >= BadLeadFloor) begin
            expect_error(STATUS_BIG_LEAD);
         end else begin
            if (d < ThreeByteLead) begin
               acc_bits   = {16'd0, d[4:0]};
               conts_left = 2'd1;
            end else if (d < FourByteLead) begin
               acc_bits   = {17'd0, d[3:0]};
               conts_left = 2'd2;
            end else begin
               acc_bits   = {18'd0, d[2:0]};
               conts_left = 2'd3;
            end
            if (last) expect_error(STATUS_INCOMPLETE);
         end
      end else if (d[7:6] != 2'b10) begin
         // the offending byte is swallowed too
         expect_error(STATUS_BAD_CONT);
      end else begin
         acc_bits   = {acc_bits[14:0], d[5:0]};
         conts_left = conts_left - 2'd1;
         if (conts_left == 2'd0) finish_code_point(acc_bits);
         else if (last) expect_error(STATUS_INCOMPLETE);
      end
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic void queue_byte(input logic bom, input logic [7:0] d,
                                      input logic last);
      utf8_beat_type b;
      b.bom  = bom;
      b.data = d;
      b.last = last;
      byte_queue.push_back(b);
      items_queued++;
   endfunction

   function automatic void queue_directed();
      queue_byte(1'b0, 8'h00, 1'b0);   // lowest ascii
      queue_byte(1'b0, 8'h7F, 1'b1);   // highest ascii, end of buffer
      queue_byte(1'b0, 8'hC0, 1'b0);   // overlong nul, passed through
      queue_byte(1'b0, 8'h80, 1'b0);
      queue_byte(1'b0, 8'hEF, 1'b0);   // ffff with a bom in the middle
      queue_byte(1'b1, 8'hFF, 1'b1);
      queue_byte(1'b0, 8'hBF, 1'b0);
      queue_byte(1'b0, 8'hBF, 1'b0);
      queue_byte(1'b0, 8'hF4, 1'b0);   // 10ffff, top of the range
      queue_byte(1'b0, 8'h8F, 1'b0);
      queue_byte(1'b0, 8'hBF, 1'b0);
      queue_byte(1'b0, 8'hBF, 1'b0);
      queue_byte(1'b0, 8'hF7, 1'b0);   // 1fffff, beyond the range
      queue_byte(1'b0, 8'hBF, 1'b0);
      queue_byte(1'b0, 8'hBF, 1'b0);
      queue_byte(1'b0, 8'hBF, 1'b0);
      queue_byte(1'b0, 8'h80, 1'b0);   // stray continuation
      queue_byte(1'b0, 8'hF8, 1'b0);   // leads that can never start a sequence
      queue_byte(1'b0, 8'hFF, 1'b0);
      queue_byte(1'b0, 8'hE2, 1'b0);   // bad continuation, the 41 is dropped
      queue_byte(1'b0, 8'h41, 1'b0);
      queue_byte(1'b0, 8'hC3, 1'b1);   // lead cut off by end of buffer
      queue_byte(1'b0, 8'hE2, 1'b0);   // continuation cut off by end of buffer
      queue_byte(1'b0, 8'h82, 1'b1);
   endfunction

   // mostly well-formed code points, some truncated, damaged, plain noise or a byte order mark
   task automatic queue_random_sequence();
      int          kind;
      int          nbytes;
      int          cut;
      int          spot;
      logic [1:0]  top;
      logic [20:0] cp;
      logic [7:0]  enc [4];
      logic        cut_short;
      kind      = $urandom_range(0, 99);
      cut_short = 1'b0;
      if (kind < 6) begin
         queue_byte(1'b1, 8'($urandom), 1'($urandom_range(0, 1)));
         return;
      end
      if (kind < 14) begin
         queue_byte(1'b0, 8'($urandom), ($urandom_range(0, 9) == 0));
         return;
      end
      if (kind < 34) begin
         nbytes = 1;
         cp     = 21'($urandom_range(0, 'h7F));
      end else if (kind < 52) begin
         nbytes = 2;
         cp     = 21'($urandom_range(0, 'h7FF));
      end else if (kind < 72) begin
         nbytes = 3;
         cp     = 21'($urandom_range(0, 'hFFFF));
      end else begin
         nbytes = 4;
         case ($urandom_range(0, 9))
            7: begin
               cp = 21'($urandom_range('h110000, 'h1FFFFF));
            end
            8: begin
               cp = 21'($urandom_range(0, 'h1FFFFF));
            end
            default: begin
               cp = 21'($urandom_range('h10000, 'h10FFFF));
            end
         endcase
      end
      case (nbytes)
         1: begin
            enc[0] = {1'b0, cp[6:0]};
         end
         2: begin
            enc[0] = {3'b110, cp[10:6]};
            enc[1] = {2'b10, cp[5:0]};
         end
         3: begin
            enc[0] = {4'b1110, cp[15:12]};
            enc[1] = {2'b10, cp[11:6]};
            enc[2] = {2'b10, cp[5:0]};
         end
         default: begin
            enc[0] = {5'b11110, cp[20:18]};
            enc[1] = {2'b10, cp[17:12]};
            enc[2] = {2'b10, cp[11:6]};
            enc[3] = {2'b10, cp[5:0]};
         end
      endcase
      cut = nbytes;
      if (nbytes > 1 && $urandom_range(0, 9) == 0) begin
         spot = $urandom_range(1, nbytes - 1);
         top  = 2'($urandom_range(0, 2));
         if (top == 2'b10) top = 2'b11;
         enc[spot] = {top, 6'($urandom)};
      end else if (nbytes > 1 && $urandom_range(0, 9) == 0) begin
         cut       = $urandom_range(1, nbytes - 1);
         cut_short = 1'b1;
      end
      for (int i = 0; i < cut; i++) begin
         if (i == cut - 1) begin
            queue_byte(1'b0, enc[i], cut_short || ($urandom_range(0, 7) == 0));
         end else begin
            queue_byte(1'b0, enc[i], 1'b0);
         end
         if (i == 0 && cut > 1 && $urandom_range(0, 19) == 0) begin
            queue_byte(1'b1, 8'($urandom), 1'($urandom_range(0, 1)));
         end
      end
   endtask

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid    <= 1'b0;
         send_wait     = 0;
         sender_steady = 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            decode_utf8_beat(req_tuser, req_tdata, req_tlast);
            bytes_sent++;
            send_wait = sender_steady ? 0 : $urandom_range(0, 3);
            if ($urandom_range(0, 39) == 0) sender_steady = ~sender_steady;
         end
         if (!req_tvalid || req_tready) begin
            if (send_wait > 0) begin
               send_wait--;
               req_tvalid <= 1'b0;
            end else if (byte_queue.size() > 0) begin
               beat_out = byte_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= beat_out.bom;
               req_tdata  <= beat_out.data;
               req_tlast  <= beat_out.last;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   function automatic void note_error(input string what);
      error_count++;
      if (error_count <= ReportLimit) $display("ERROR at %0t: %s", $realtime, what);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready      <= 1'b0;
         recv_wait       = 0;
         receiver_steady = 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            units_checked++;
            status_hits[rsp_tdata[18:16]]++;
            if (units_due.size() == 0) begin
               note_error($sformatf("unit %h status %0d last %b with nothing due",
                                    rsp_tdata[15:0], rsp_tdata[18:16], rsp_tlast));
            end else begin
               want = units_due.pop_front();
               if (rsp_tdata[15:0] !== want.code_unit)
                  note_error($sformatf("code unit: expected %h, got %h",
                                       want.code_unit, rsp_tdata[15:0]));
               if (rsp_tdata[18:16] !== want.status)
                  note_error($sformatf("status: expected %0d, got %0d",
                                       want.status, rsp_tdata[18:16]));
               if (rsp_tlast !== want.last_of_run)
                  note_error($sformatf("last of run: expected %b, got %b",
                                       want.last_of_run, rsp_tlast));
            end
            recv_wait = receiver_steady ? 0 : $urandom_range(0, 3);
            if ($urandom_range(0, 39) == 0) receiver_steady = ~receiver_steady;
         end
         if (recv_wait > 0) begin
            recv_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- watchdog

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= StallLimit) begin
         $display("timeout: no beat for %0d cycles, %0d units still due",
                  StallLimit, units_due.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // ---------------------------------------------------------------- sequencing

   // sampled on the falling edge so the driver's updates have settled
   task automatic wait_idle();
      do @(negedge clock);
      while (byte_queue.size() != 0 || req_tvalid || units_due.size() != 0);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_byte_order(input logic big_endian);
      @(posedge clock);
      csr_wr_en      <= 1'b1;
      csr_wr_data    <= big_endian;
      cfg_big_endian = big_endian;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      config_writes++;
   endtask

   initial begin
      int unsigned goal;
      acc_bits       = '0;
      conts_left     = '0;
      cfg_big_endian = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      write_byte_order(1'b0);
      queue_directed();
      wait_idle();
      write_byte_order(1'b1);
      queue_directed();

      for (int phase = 0; phase < 4; phase++) begin
         wait_idle();
         write_byte_order(phase[0]);
         goal = items_queued + RandomPerPhase;
         while (items_queued < goal) queue_random_sequence();
      end
      wait_idle();

      $display("%0d input beats, %0d code units checked, %0d byte order writes",
               bytes_sent, units_checked, config_writes);
      $display("status seen: ok %0d stray %0d big lead %0d bad cont %0d range %0d cut %0d",
               status_hits[STATUS_OK], status_hits[STATUS_STRAY],
               status_hits[STATUS_BIG_LEAD], status_hits[STATUS_BAD_CONT],
               status_hits[STATUS_RANGE], status_hits[STATUS_INCOMPLETE]);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// File: sim.f
hdl/u2u_pkg.sv
hdl/u2u_decode.sv
hdl/u2u_out_fifo.sv
hdl/utf8_to_utf16_decoder_top.sv
hdl/u2u_checker.sv
test/tb_top.sv
